// ----- rtl/acm_pkg.sv -----
// Shared constants and types for the axis calibration and mapping block.
package acm_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned HALF_BITS   = 14;  // 0.5 in Q1.15 is 2**14
  localparam int unsigned OUT_BITS    = 16;
  localparam int unsigned QUOT_BITS   = (SAMPLE_BITS > HALF_BITS) ? SAMPLE_BITS : HALF_BITS;
  localparam int unsigned CNT_BITS    = $clog2(QUOT_BITS + 1);

  localparam logic [SAMPLE_BITS-1:0] SampleMax = {SAMPLE_BITS{1'b1}};

  localparam int unsigned FallbackLowInt  = (100  > (2**SAMPLE_BITS - 1)) ?
                                            (2**SAMPLE_BITS - 1) : 100;
  localparam int unsigned FallbackHighInt = (3900 > (2**SAMPLE_BITS - 1)) ?
                                            (2**SAMPLE_BITS - 1) : 3900;
  localparam logic [SAMPLE_BITS-1:0] FallbackLow  = FallbackLowInt[SAMPLE_BITS-1:0];
  localparam logic [SAMPLE_BITS-1:0] FallbackHigh = FallbackHighInt[SAMPLE_BITS-1:0];

  localparam int unsigned MarginDivInt = 20;
  localparam logic [SAMPLE_BITS-1:0] MarginDiv = MarginDivInt[SAMPLE_BITS-1:0];

  localparam int unsigned CenterResetInt = 2048 % (2**SAMPLE_BITS);
  localparam logic [SAMPLE_BITS-1:0] CenterReset = CenterResetInt[SAMPLE_BITS-1:0];

  localparam logic [OUT_BITS-1:0] HalfQ15 = OUT_BITS'(1) << HALF_BITS;
  localparam logic [OUT_BITS-1:0] OneQ15  = OUT_BITS'(1) << (HALF_BITS + 1);

  typedef enum logic [1:0] {
    MODE_MAP     = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_SWEEP   = 2'd2,
    MODE_FINISH  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN_PREP,
    ST_DIV_MARGIN,
    ST_FIN_PAD,
    ST_FIN_CTR,
    ST_MAP_PREP,
    ST_DIV_MAP,
    ST_RESULT
  } state_e;

endpackage

// ----- rtl/axis_calibrate_and_map.sv -----
// Axis calibration and piecewise-linear mapping to Q1.15 intensity.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  input   | in        | in_valid_i / in_ready_o| sample_i, mode_i
//  output  | out       | out_valid_o/out_ready_i| intensity_o, bound_low_o, bound_center_o,
//          |           |                        | bound_high_o
//
// One beat in gives one beat out; one restoring divider (a quotient bit a cycle)
// sets the latency. A map beat skips the divider when the sample lies on or outside
// a bound, else it runs prep, 14 divide steps, result. A finish beat first runs
// prep, 12 margin divide steps, pad and center.
// in_ready_o is high only in idle, also while a result waits in the output register;
// a stalled output holds the result state. Reset loads default bounds, clears sweep.
module axis_calibrate_and_map (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [acm_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [1:0]                         mode_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [acm_pkg::OUT_BITS-1:0]       intensity_o,
  output logic [acm_pkg::SAMPLE_BITS-1:0]    bound_low_o,
  output logic [acm_pkg::SAMPLE_BITS-1:0]    bound_center_o,
  output logic [acm_pkg::SAMPLE_BITS-1:0]    bound_high_o
);

  localparam int unsigned SB = acm_pkg::SAMPLE_BITS;
  localparam int unsigned QB = acm_pkg::QUOT_BITS;
  localparam int unsigned CB = acm_pkg::CNT_BITS;
  localparam int unsigned OB = acm_pkg::OUT_BITS;
  localparam int unsigned HB = acm_pkg::HALF_BITS;

  acm_pkg::state_e state_q, state_d;

  // Calibration and sweep state
  logic [SB-1:0] cal_low_q, cal_low_d;
  logic [SB-1:0] cal_center_q, cal_center_d;
  logic [SB-1:0] cal_high_q, cal_high_d;
  logic [SB-1:0] sweep_low_q, sweep_low_d;
  logic [SB-1:0] sweep_high_q, sweep_high_d;
  logic [SB-1:0] capt_q, capt_d;

  // Working registers
  logic [SB-1:0] sample_q, sample_d;
  logic [SB-1:0] lo_q, lo_d;
  logic [SB-1:0] hi_q, hi_d;
  logic [OB-1:0] base_q, base_d;

  // Shared divider
  logic [SB:0]   rem_q, rem_d;
  logic [SB-1:0] dvs_q, dvs_d;
  logic [SB-1:0] shin_q, shin_d;
  logic [QB-1:0] quot_q, quot_d;
  logic [CB-1:0] cnt_q, cnt_d;

  // Output register
  logic          ovalid_q, ovalid_d;
  logic [OB-1:0] o_int_q, o_int_d;
  logic [SB-1:0] o_lo_q, o_lo_d;
  logic [SB-1:0] o_ctr_q, o_ctr_d;
  logic [SB-1:0] o_hi_q, o_hi_d;

  // Divider step: shift in next dividend bit, subtract if it fits.
  logic [SB:0] div_shift;
  logic        div_ge;
  logic [SB:0] div_rem;
  always_comb begin
    div_shift = {rem_q[SB-1:0], shin_q[SB-1]};
    div_ge    = (div_shift >= {1'b0, dvs_q});
    div_rem   = div_ge ? (div_shift - {1'b0, dvs_q}) : div_shift;
  end

  logic          in_fire;
  logic          out_free;
  logic [SB:0]   hi_pad;
  logic [SB-1:0] margin;

  assign in_ready_o = (state_q == acm_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !ovalid_q || out_ready_i;
  assign margin     = quot_q[SB-1:0];
  assign hi_pad     = {1'b0, hi_q} + {1'b0, margin};

  always_comb begin
    state_d      = state_q;
    cal_low_d    = cal_low_q;
    cal_center_d = cal_center_q;
    cal_high_d   = cal_high_q;
    sweep_low_d  = sweep_low_q;
    sweep_high_d = sweep_high_q;
    capt_d       = capt_q;
    sample_d     = sample_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    base_d       = base_q;
    rem_d        = rem_q;
    dvs_d        = dvs_q;
    shin_d       = shin_q;
    quot_d       = quot_q;
    cnt_d        = cnt_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    o_int_d      = o_int_q;
    o_lo_d       = o_lo_q;
    o_ctr_d      = o_ctr_q;
    o_hi_d       = o_hi_q;

    unique case (state_q)
      acm_pkg::ST_IDLE: begin
        if (in_fire) begin
          sample_d = sample_i;
          unique case (acm_pkg::mode_e'(mode_i))
            acm_pkg::MODE_CAPTURE: begin
              capt_d       = sample_i;
              sweep_low_d  = sample_i;
              sweep_high_d = sample_i;
              state_d      = acm_pkg::ST_MAP_PREP;
            end
            acm_pkg::MODE_SWEEP: begin
              if (sample_i < sweep_low_q) sweep_low_d = sample_i;
              if (sample_i > sweep_high_q) sweep_high_d = sample_i;
              state_d = acm_pkg::ST_MAP_PREP;
            end
            acm_pkg::MODE_FINISH: state_d = acm_pkg::ST_FIN_PREP;
            default:              state_d = acm_pkg::ST_MAP_PREP;
          endcase
        end
      end
      acm_pkg::ST_FIN_PREP: begin
        // no sweep: fall back to fixed bounds
        if (sweep_high_q <= sweep_low_q) begin
          lo_d   = acm_pkg::FallbackLow;
          hi_d   = acm_pkg::FallbackHigh;
          shin_d = acm_pkg::FallbackHigh - acm_pkg::FallbackLow;
        end else begin
          lo_d   = sweep_low_q;
          hi_d   = sweep_high_q;
          shin_d = sweep_high_q - sweep_low_q;
        end
        rem_d   = '0;
        dvs_d   = acm_pkg::MarginDiv;
        quot_d  = '0;
        cnt_d   = CB'(SB);
        state_d = acm_pkg::ST_DIV_MARGIN;
      end
      acm_pkg::ST_DIV_MARGIN, acm_pkg::ST_DIV_MAP: begin
        rem_d  = div_rem;
        shin_d = {shin_q[SB-2:0], 1'b0};
        quot_d = {quot_q[QB-2:0], div_ge};
        cnt_d  = cnt_q - CB'(1);
        if (cnt_q == CB'(1)) begin
          state_d = (state_q == acm_pkg::ST_DIV_MARGIN) ? acm_pkg::ST_FIN_PAD
                                                          : acm_pkg::ST_RESULT;
        end
      end
      acm_pkg::ST_FIN_PAD: begin
        lo_d    = (lo_q > margin) ? (lo_q - margin) : '0;
        hi_d    = (hi_pad > {1'b0, acm_pkg::SampleMax}) ? acm_pkg::SampleMax
                                                        : hi_pad[SB-1:0];
        state_d = acm_pkg::ST_FIN_CTR;
      end
      acm_pkg::ST_FIN_CTR: begin
        cal_center_d = capt_q;
        if (capt_q <= lo_q) cal_center_d = lo_q + SB'(1);
        if (cal_center_d >= hi_q) cal_center_d = hi_q - SB'(1);
        cal_low_d  = lo_q;
        cal_high_d = hi_q;
        state_d    = acm_pkg::ST_MAP_PREP;
      end
      acm_pkg::ST_MAP_PREP: begin
        quot_d = '0;
        shin_d = '0;
        cnt_d  = CB'(HB);
        if (sample_q <= cal_low_q) begin
          base_d  = '0;
          state_d = acm_pkg::ST_RESULT;
        end else if (sample_q >= cal_high_q) begin
          base_d  = acm_pkg::OneQ15;
          state_d = acm_pkg::ST_RESULT;
        end else if (sample_q < cal_center_q) begin
          base_d  = '0;
          rem_d   = {1'b0, sample_q - cal_low_q};
          dvs_d   = cal_center_q - cal_low_q;
          state_d = acm_pkg::ST_DIV_MAP;
        end else begin
          base_d  = acm_pkg::HalfQ15;
          rem_d   = {1'b0, sample_q - cal_center_q};
          dvs_d   = cal_high_q - cal_center_q;
          state_d = acm_pkg::ST_DIV_MAP;
        end
      end
      acm_pkg::ST_RESULT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          o_int_d  = base_q + OB'(quot_q[HB-1:0]);
          o_lo_d   = cal_low_q;
          o_ctr_d  = cal_center_q;
          o_hi_d   = cal_high_q;
          state_d  = acm_pkg::ST_IDLE;
        end
      end
      default: state_d = acm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acm_pkg::ST_IDLE;
      cal_low_q    <= '0;
      cal_center_q <= acm_pkg::CenterReset;
      cal_high_q   <= acm_pkg::SampleMax;
      sweep_low_q  <= '0;
      sweep_high_q <= '0;
      capt_q       <= '0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      cal_low_q    <= cal_low_d;
      cal_center_q <= cal_center_d;
      cal_high_q   <= cal_high_d;
      sweep_low_q  <= sweep_low_d;
      sweep_high_q <= sweep_high_d;
      capt_q       <= capt_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    base_q   <= base_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    shin_q   <= shin_d;
    quot_q   <= quot_d;
    cnt_q    <= cnt_d;
    o_int_q  <= o_int_d;
    o_lo_q   <= o_lo_d;
    o_ctr_q  <= o_ctr_d;
    o_hi_q   <= o_hi_d;
  end

  assign out_valid_o    = ovalid_q;
  assign intensity_o    = o_int_q;
  assign bound_low_o    = o_lo_q;
  assign bound_center_o = o_ctr_q;
  assign bound_high_o   = o_hi_q;

  // Divider remainder always stays below the divisor while stepping.
  a_rem_below_dvs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acm_pkg::ST_DIV_MAP || state_q == acm_pkg::ST_DIV_MARGIN)
      |-> (rem_q < {1'b0, dvs_q}))
    else $error("divider remainder not below divisor");

  // Calibrated bounds never collapse or invert.
  a_bounds_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_low_q < cal_high_q)
    else $error("calibrated low not below high");

  // A loaded result never exceeds 1.0 in Q1.15.
  a_int_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acm_pkg::ST_RESULT && out_free) |=> (o_int_q <= acm_pkg::OneQ15))
    else $error("intensity above 1.0");

endmodule

// ----- test/tb_axis_calibrate_and_map.sv -----
// Self-checking testbench for the axis calibration and Q1.15 mapping block.
`timescale 1ns / 100ps

module tb_axis_calibrate_and_map;

  localparam int unsigned SB         = acm_pkg::SAMPLE_BITS;
  localparam int unsigned OB         = acm_pkg::OUT_BITS;
  localparam int unsigned SMAX       = (1 << SB) - 1;
  localparam int unsigned FB_LOW     = 100;
  localparam int unsigned FB_HIGH    = 3900;
  localparam int unsigned PAD_DIV    = 20;
  localparam int unsigned Q15_HALF   = 16384;
  localparam int unsigned Q15_ONE    = 32768;
  localparam int          RAND_BEATS = 1800;
  localparam int          DRAIN_CYC  = 64;       // finish beat is the longest beat
  localparam int          CYCLE_CAP  = 600000;
  localparam int          IDLE_PCT   = 22;

  // One output beat: intensity plus the bounds in use.
  typedef struct packed {
    logic [OB-1:0] intensity;
    logic [SB-1:0] lo;
    logic [SB-1:0] ctr;
    logic [SB-1:0] hi;
  } axis_res_t;

  // Directed row; typed rows carry a hand-read expectation.
  typedef struct {
    logic [SB-1:0]  sample;
    acm_pkg::mode_e mode;
    bit             typed;
    logic [OB-1:0]  intensity;
    logic [SB-1:0]  lo;
    logic [SB-1:0]  ctr;
    logic [SB-1:0]  hi;
  } dir_row_t;

  localparam int N_DIR = 26;

  dir_row_t dir_tab [N_DIR] = '{
    // reset bounds: both extremes and the center
    '{12'd0,    acm_pkg::MODE_MAP,     1'b1, 16'd0,     12'd0, 12'd2048, 12'd4095},
    '{12'd4095, acm_pkg::MODE_MAP,     1'b1, 16'd32768, 12'd0, 12'd2048, 12'd4095},
    '{12'd2048, acm_pkg::MODE_MAP,     1'b1, 16'd16384, 12'd0, 12'd2048, 12'd4095},
    '{12'd1024, acm_pkg::MODE_MAP,     1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd3071, acm_pkg::MODE_MAP,     1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    // sweep and finish with no capture: sweep grows from 0..0, center pushed to 1
    '{12'd500,  acm_pkg::MODE_SWEEP,   1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd4095, acm_pkg::MODE_FINISH,  1'b1, 16'd32768, 12'd0, 12'd1,    12'd525},
    '{12'd1,    acm_pkg::MODE_MAP,     1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    // capture then finish with no sweep: fallback bounds
    '{12'd2048, acm_pkg::MODE_CAPTURE, 1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd0,    acm_pkg::MODE_FINISH,  1'b1, 16'd0,     12'd0, 12'd2048, 12'd4090},
    // full-range sweep, padding clamps at both ends
    '{12'd2000, acm_pkg::MODE_CAPTURE, 1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd0,    acm_pkg::MODE_SWEEP,   1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd4095, acm_pkg::MODE_SWEEP,   1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd1234, acm_pkg::MODE_FINISH,  1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    // center pushed down from the top, then up from the bottom
    '{12'd4095, acm_pkg::MODE_CAPTURE, 1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd4095, acm_pkg::MODE_FINISH,  1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd0,    acm_pkg::MODE_CAPTURE, 1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd0,    acm_pkg::MODE_FINISH,  1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    // narrow sweep, margin of one
    '{12'd2000, acm_pkg::MODE_CAPTURE, 1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd1990, acm_pkg::MODE_SWEEP,   1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd2010, acm_pkg::MODE_SWEEP,   1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd1995, acm_pkg::MODE_FINISH,  1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd2005, acm_pkg::MODE_MAP,     1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    // one-code sweep: zero margin, center lands on the low bound
    '{12'd1000, acm_pkg::MODE_CAPTURE, 1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd1001, acm_pkg::MODE_SWEEP,   1'b0, 16'd0,     12'd0, 12'd0,    12'd0},
    '{12'd1000, acm_pkg::MODE_FINISH,  1'b0, 16'd0,     12'd0, 12'd0,    12'd0}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [SB-1:0] sample_i;
  logic [1:0]    mode_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [OB-1:0] intensity_o;
  logic [SB-1:0] bound_low_o;
  logic [SB-1:0] bound_center_o;
  logic [SB-1:0] bound_high_o;

  // Expectation riding along with the payload for typed directed rows.
  bit        drv_typed;
  axis_res_t drv_exp;
  bit        no_idle;

  // Predictor state.
  logic [SB-1:0] cal_lo_q, cal_ctr_q, cal_hi_q;
  logic [SB-1:0] sweep_lo_q, sweep_hi_q, rest_q;

  axis_res_t expected_q [$];
  int        n_err;
  int        n_checked;
  int        n_finish_done;
  int        mode_cnt [4];
  int        cycles;

  axis_calibrate_and_map u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .mode_i         (mode_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .intensity_o    (intensity_o),
    .bound_low_o    (bound_low_o),
    .bound_center_o (bound_center_o),
    .bound_high_o   (bound_high_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Piecewise-linear map through the current calibrated bounds.
  function automatic logic [OB-1:0] map_q15(logic [SB-1:0] v);
    int unsigned span;
    int unsigned res;
    if (v <= cal_lo_q) begin
      res = 0;
    end else if (v >= cal_hi_q) begin
      res = Q15_ONE;
    end else if (v < cal_ctr_q) begin
      span = cal_ctr_q - cal_lo_q;
      res  = (span == 0) ? 0 : (Q15_HALF * (v - cal_lo_q)) / span;
    end else begin
      span = cal_hi_q - cal_ctr_q;
      res  = (span == 0) ? Q15_HALF : Q15_HALF + (Q15_HALF * (v - cal_ctr_q)) / span;
    end
    return res[OB-1:0];
  endfunction

  // Advance the predictor by one accepted beat and return its result.
  task automatic calibrate_and_map(input logic [SB-1:0] s, input acm_pkg::mode_e m,
                                   output axis_res_t r);
    int unsigned lo, hi, pad, ctr;
    case (m)
      acm_pkg::MODE_CAPTURE: begin
        rest_q     = s;
        sweep_lo_q = s;
        sweep_hi_q = s;
      end
      acm_pkg::MODE_SWEEP: begin
        if (s < sweep_lo_q) sweep_lo_q = s;
        if (s > sweep_hi_q) sweep_hi_q = s;
      end
      acm_pkg::MODE_FINISH: begin
        lo  = sweep_lo_q;
        hi  = sweep_hi_q;
        ctr = rest_q;
        if (hi <= lo) begin
          // nothing swept: fall back to fixed bounds
          lo = (FB_LOW > SMAX) ? SMAX : FB_LOW;
          hi = (FB_HIGH > SMAX) ? SMAX : FB_HIGH;
        end
        pad = (hi - lo) / PAD_DIV;
        lo  = (lo > pad) ? lo - pad : 0;
        hi  = (hi + pad > SMAX) ? SMAX : hi + pad;
        if (ctr <= lo) ctr = lo + 1;
        if (ctr >= hi) ctr = hi - 1;
        cal_lo_q  = lo[SB-1:0];
        cal_ctr_q = ctr[SB-1:0];
        cal_hi_q  = hi[SB-1:0];
        n_finish_done++;
      end
      default: ;
    endcase
    r.intensity = map_q15(s);
    r.lo        = cal_lo_q;
    r.ctr       = cal_ctr_q;
    r.hi        = cal_hi_q;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    n_err++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
  endtask

  // Input side: predict on every accepted beat.
  // Output side: compare every accepted beat with the oldest expectation.
  always @(posedge clk_i) begin
    axis_res_t r;
    axis_res_t w;
    if (rst_ni && in_valid_i && in_ready_o) begin
      calibrate_and_map(sample_i, acm_pkg::mode_e'(mode_i), r);
      expected_q.push_back(drv_typed ? drv_exp : r);
      mode_cnt[mode_i]++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", intensity_o, -1);
      end else begin
        w = expected_q.pop_front();
        n_checked++;
        if (intensity_o !== w.intensity) report_mismatch("intensity", intensity_o, w.intensity);
        if (bound_low_o !== w.lo)        report_mismatch("bound_low", bound_low_o, w.lo);
        if (bound_center_o !== w.ctr)    report_mismatch("bound_center", bound_center_o, w.ctr);
        if (bound_high_o !== w.hi)       report_mismatch("bound_high", bound_high_o, w.hi);
      end
    end
  end

  // Receiver stalls at random outside the no-idle stretch.
  always @(negedge clk_i) begin
    out_ready_i = no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, expected_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic [SB-1:0] s, input acm_pkg::mode_e m,
                           input bit typed, input axis_res_t w);
    bit took;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    mode_i     = m;
    drv_typed  = typed;
    drv_exp    = w;
    do begin
      @(posedge clk_i);
      took = in_ready_o;
      @(negedge clk_i);
    end while (!took);
  endtask

  function automatic logic [SB-1:0] near(int base, int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(SMAX)) v = int'(SMAX);
    return v[SB-1:0];
  endfunction

  // Map samples lean on the bounds, where the segment choice flips.
  function automatic logic [SB-1:0] map_pick();
    case ($urandom_range(4))
      0:       return near(cal_lo_q, 3);
      1:       return near(cal_ctr_q, 3);
      2:       return near(cal_hi_q, 3);
      3:       return $urandom_range(1) ? SB'(SMAX) : '0;
      default: return SB'($urandom_range(SMAX));
    endcase
  endfunction

  initial begin
    axis_res_t none;
    int        n_rand;
    int        rest;
    int        spread;
    int        n_sweep;
    int        n_map;

    none          = '0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    sample_i      = '0;
    mode_i        = acm_pkg::MODE_MAP;
    drv_typed     = 1'b0;
    drv_exp       = '0;
    no_idle       = 1'b0;
    n_err         = 0;
    n_checked     = 0;
    n_finish_done = 0;
    cycles        = 0;
    foreach (mode_cnt[i]) mode_cnt[i] = 0;
    cal_lo_q      = '0;
    cal_ctr_q     = acm_pkg::CenterReset;
    cal_hi_q      = acm_pkg::SampleMax;
    sweep_lo_q    = '0;
    sweep_hi_q    = '0;
    rest_q        = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].sample, dir_tab[i].mode, dir_tab[i].typed,
                '{dir_tab[i].intensity, dir_tab[i].lo, dir_tab[i].ctr, dir_tab[i].hi});
    end

    // Random part: mostly whole calibrations followed by maps, some noise.
    n_rand = 0;
    while (n_rand < RAND_BEATS) begin
      no_idle = (n_rand >= 700 && n_rand < 1000);
      if ($urandom_range(99) < 75) begin
        rest = $urandom_range(SMAX);
        case ($urandom_range(3))
          0:       spread = $urandom_range(20);
          1:       spread = $urandom_range(400);
          2:       spread = SMAX;
          default: spread = $urandom_range(1500);
        endcase
        if ($urandom_range(9) != 0) begin
          send_beat(rest[SB-1:0], acm_pkg::MODE_CAPTURE, 1'b0, none);
          n_rand++;
        end
        n_sweep = $urandom_range(8);
        repeat (n_sweep) begin
          send_beat(near(rest, spread), acm_pkg::MODE_SWEEP, 1'b0, none);
          n_rand++;
        end
        send_beat(SB'($urandom_range(SMAX)), acm_pkg::MODE_FINISH, 1'b0, none);
        n_rand++;
        n_map = $urandom_range(20, 3);
        repeat (n_map) begin
          send_beat(map_pick(), acm_pkg::MODE_MAP, 1'b0, none);
          n_rand++;
        end
      end else begin
        send_beat(SB'($urandom_range(SMAX)), acm_pkg::mode_e'($urandom_range(3)), 1'b0, none);
        n_rand++;
      end
    end
    in_valid_i = 1'b0;
    no_idle    = 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (expected_q.size() != 0) report_mismatch("results never delivered", 0, expected_q.size());

    $display("beats in: map %0d, capture %0d, sweep %0d, finish %0d (%0d calibrations applied)",
             mode_cnt[acm_pkg::MODE_MAP], mode_cnt[acm_pkg::MODE_CAPTURE],
             mode_cnt[acm_pkg::MODE_SWEEP], mode_cnt[acm_pkg::MODE_FINISH], n_finish_done);
    $display("beats out compared: %0d, mismatches: %0d", n_checked, n_err);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
